/* design/bpa_pkg.sv */
`default_nettype none

package bpa_pkg;

   // Field widths of the request, response and configuration transactions.
   localparam int ACTION_W = 2;
   localparam int ORDER_W  = 4;
   localparam int PAGE_W   = 18;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 32;

   // Default sizing of the allocator.
   localparam int MAX_ORDER_DEF   = 10;
   localparam int STACK_DEPTH_DEF = 256;

   // Value of the total-pages register after reset.
   localparam logic [PAGE_W-1:0] TOTAL_RESET = 18'd1024;

   // Request actions.
   localparam logic [ACTION_W-1:0] ACT_ALLOC  = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_FREE   = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_REINIT = 2'd2;

   // Response status codes.
   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NO_BLOCK  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BAD_ORDER = 2'd2;

endpackage

`default_nettype wire

/* design/bpa_req_if.sv */
`default_nettype none

// Request channel: action, block order and the page of a freed block.
interface bpa_req_if;
   logic                          valid;
   logic                          ready;
   logic [bpa_pkg::ACTION_W-1:0]  action;
   logic [bpa_pkg::ORDER_W-1:0]   block_order;
   logic [bpa_pkg::PAGE_W-1:0]    block_page;

   modport source (output valid, output action, output block_order, output block_page,
                   input ready);
   modport sink   (input valid, input action, input block_order, input block_page,
                   output ready);
endinterface

`default_nettype wire

/* design/bpa_rsp_if.sv */
`default_nettype none

// Response channel: one transaction for every request.
interface bpa_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [bpa_pkg::STATUS_W-1:0]  status;
   logic [bpa_pkg::PAGE_W-1:0]    granted_page;
   logic                          push_dropped;
   logic [bpa_pkg::COUNT_W-1:0]   free_page_count;

   modport source (output valid, output status, output granted_page, output push_dropped,
                   output free_page_count, input ready);
   modport sink   (input valid, input status, input granted_page, input push_dropped,
                   input free_page_count, output ready);
endinterface

`default_nettype wire

/* design/bpa_csr_if.sv */
`default_nettype none

// Configuration write channel for the total-pages register.
interface bpa_csr_if;
   logic                        valid;
   logic                        ready;
   logic [bpa_pkg::PAGE_W-1:0]  page_total;

   modport source (output valid, output page_total, input ready);
   modport sink   (input valid, input page_total, output ready);
endinterface

`default_nettype wire

/* design/buddy_page_allocator_core.sv */
`default_nettype none

// Buddy page allocator without coalescing. One LIFO of free block page numbers is kept per
// order 0..MAX_ORDER in a single RAM; the fill count of each LIFO lives in flip-flops. A
// small sequencer drives one RAM port pair, so one transaction is handled at a time and
// req_ch.ready is high only while the sequencer is idle. A free pushes its page onto the
// stack of its order. An allocate skips empty orders upward from the requested one, pops the
// first non-empty stack and splits down to the requested order (one RAM write per split
// buddy). A reinitialize lists blocks greedily from order MAX_ORDER down to order 1, one RAM
// write per listed block; at most STACK_DEPTH blocks are listed on one order. After reset the
// same greedy fill runs from the reset value of total_pages with req_ch.ready low and no
// response. A finished response waits in an output register, so the next request is accepted
// while the previous response is still pending. Configuration writes are accepted in every
// cycle outside reset.
module buddy_page_allocator_core #(
   parameter int MAX_ORDER   = bpa_pkg::MAX_ORDER_DEF,
   parameter int STACK_DEPTH = bpa_pkg::STACK_DEPTH_DEF
) (
   input wire logic  clock,
   input wire logic  reset,
   bpa_req_if.sink   req_ch,
   bpa_rsp_if.source rsp_ch,
   bpa_csr_if.sink   csr_ch
);

   localparam int PAGE_W      = bpa_pkg::PAGE_W;
   localparam int COUNT_W     = bpa_pkg::COUNT_W;
   localparam int STATUS_W    = bpa_pkg::STATUS_W;
   localparam int ORDER_COUNT = MAX_ORDER + 1;
   localparam int OA_W        = $clog2(ORDER_COUNT);
   localparam int CUR_W       = $clog2(MAX_ORDER + 2);
   localparam int IDX_W       = $clog2(STACK_DEPTH);
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int RAM_DEPTH   = ORDER_COUNT << IDX_W;
   localparam int ADDR_W      = OA_W + IDX_W;

   localparam logic [CNT_W-1:0]  DEPTH_CNT  = CNT_W'(STACK_DEPTH);
   localparam logic [PAGE_W-1:0] DEPTH_PAGE = PAGE_W'(STACK_DEPTH);
   localparam logic [CUR_W-1:0]  MAX_CUR    = CUR_W'(MAX_ORDER);
   localparam logic [CUR_W-1:0]  CUR_ONE    = CUR_W'(1);

   // Sequencer states.
   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_SCAN    = 4'd1;
   localparam logic [3:0] S_READ    = 4'd2;
   localparam logic [3:0] S_SPLIT   = 4'd3;
   localparam logic [3:0] S_FREE    = 4'd4;
   localparam logic [3:0] S_DONE    = 4'd5;
   localparam logic [3:0] S_RF_INIT = 4'd6;
   localparam logic [3:0] S_RF_ORD  = 4'd7;
   localparam logic [3:0] S_RF_PUSH = 4'd8;

   logic [3:0]          state_ff, state_in;
   logic [CUR_W-1:0]    ord_ff, ord_in;
   logic [CUR_W-1:0]    cur_ff, cur_in;
   logic [PAGE_W-1:0]   page_ff, page_in;
   logic [PAGE_W-1:0]   granted_ff, granted_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic                dropped_ff, dropped_in;
   logic                report_ff, report_in;
   logic [COUNT_W-1:0]  counter_ff, counter_in;
   logic [CNT_W-1:0]    fill_ff [ORDER_COUNT];
   logic [CNT_W-1:0]    fill_in [ORDER_COUNT];
   logic [PAGE_W-1:0]   total_ff;

   // Refill walk: pages not yet listed, first page of this order's run, next page, block count.
   logic [PAGE_W-1:0]   rem_ff, rem_in;
   logic [PAGE_W-1:0]   base_ff, base_in;
   logic [PAGE_W-1:0]   ptr_ff, ptr_in;
   logic [PAGE_W-1:0]   blocks_ff, blocks_in;

   // Response output register.
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [PAGE_W-1:0]   rsp_granted_ff;
   logic                rsp_dropped_ff;
   logic [COUNT_W-1:0]  rsp_count_ff;
   logic                rsp_load;

   // RAM ports.
   logic                ram_wr_en;
   logic [ADDR_W-1:0]   ram_wr_addr;
   logic [PAGE_W-1:0]   ram_wr_data;
   logic                ram_rd_en;
   logic [ADDR_W-1:0]   ram_rd_addr;
   logic [PAGE_W-1:0]   ram_rd_data;

   // Shared fill-count port and derived values.
   logic [CUR_W-1:0]    nxt_cur;
   logic [OA_W-1:0]     fill_sel_ix;
   logic [CNT_W-1:0]    fill_sel;
   logic [CNT_W-1:0]    fill_top;
   logic [PAGE_W-1:0]   split_page;
   logic [PAGE_W-1:0]   rf_step;
   logic [PAGE_W-1:0]   rf_mask;
   logic                req_accept;
   logic                order_ok;

   bpa_ram #(
      .WIDTH (PAGE_W),
      .DEPTH (RAM_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_accept   = req_ch.valid && req_ch.ready;
   assign order_ok     = (32'(req_ch.block_order) <= 32'(MAX_ORDER));
   assign csr_ch.ready = !reset;

   // One fill count is looked at per cycle; the state picks which order.
   assign nxt_cur = cur_ff - CUR_ONE;
   always_comb begin
      unique case (state_ff)
         S_SPLIT: fill_sel_ix = nxt_cur[OA_W-1:0];
         S_FREE:  fill_sel_ix = ord_ff[OA_W-1:0];
         default: fill_sel_ix = cur_ff[OA_W-1:0];
      endcase
   end
   assign fill_sel = fill_ff[fill_sel_ix];
   assign fill_top = fill_sel - CNT_W'(1);

   assign split_page = granted_ff + (PAGE_W'(1) << nxt_cur);
   assign rf_step    = PAGE_W'(1) << cur_ff;
   assign rf_mask    = rf_step - PAGE_W'(1);

   // Sequencer next-state and datapath.
   always_comb begin
      state_in     = state_ff;
      ord_in       = ord_ff;
      cur_in       = cur_ff;
      page_in      = page_ff;
      granted_in   = granted_ff;
      status_in    = status_ff;
      dropped_in   = dropped_ff;
      report_in    = report_ff;
      counter_in   = counter_ff;
      fill_in      = fill_ff;
      rem_in       = rem_ff;
      base_in      = base_ff;
      ptr_in       = ptr_ff;
      blocks_in    = blocks_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = {fill_sel_ix, fill_sel[IDX_W-1:0]};
      ram_wr_data  = split_page;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = {fill_sel_ix, fill_top[IDX_W-1:0]};
      rsp_load     = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               ord_in     = CUR_W'(req_ch.block_order);
               cur_in     = CUR_W'(req_ch.block_order);
               page_in    = req_ch.block_page;
               granted_in = '0;
               status_in  = bpa_pkg::ST_OK;
               dropped_in = 1'b0;
               unique case (req_ch.action)
                  bpa_pkg::ACT_ALLOC: begin
                     if (order_ok) begin
                        state_in = S_SCAN;
                     end else begin
                        status_in = bpa_pkg::ST_BAD_ORDER;
                        state_in  = S_DONE;
                     end
                  end
                  bpa_pkg::ACT_FREE: begin
                     if (order_ok) begin
                        state_in = S_FREE;
                     end else begin
                        status_in = bpa_pkg::ST_BAD_ORDER;
                        state_in  = S_DONE;
                     end
                  end
                  bpa_pkg::ACT_REINIT: begin
                     report_in = 1'b1;
                     state_in  = S_RF_INIT;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end

         // Walk upward for a non-empty stack; pop its top when found, else report no block.
         S_SCAN: begin
            if (cur_ff > MAX_CUR) begin
               status_in = bpa_pkg::ST_NO_BLOCK;
               state_in  = S_DONE;
            end else if (fill_sel == '0) begin
               cur_in = cur_ff + CUR_ONE;
            end else begin
               ram_rd_en             = 1'b1;
               fill_in[fill_sel_ix]  = fill_top;
               state_in              = S_READ;
            end
         end

         S_READ: begin
            granted_in = ram_rd_data;
            state_in   = S_SPLIT;
         end

         // Split down one order a cycle, listing the upper buddy each time unless its stack is full.
         S_SPLIT: begin
            if (cur_ff == ord_ff) begin
               counter_in = counter_ff - (COUNT_W'(1) << ord_ff);
               state_in   = S_DONE;
            end else begin
               cur_in = nxt_cur;
               if (fill_sel < DEPTH_CNT) begin
                  ram_wr_en            = 1'b1;
                  fill_in[fill_sel_ix] = fill_sel + CNT_W'(1);
               end else begin
                  dropped_in = 1'b1;
               end
            end
         end

         S_FREE: begin
            ram_wr_data = page_ff;
            counter_in  = counter_ff + (COUNT_W'(1) << ord_ff);
            if (fill_sel < DEPTH_CNT) begin
               ram_wr_en            = 1'b1;
               fill_in[fill_sel_ix] = fill_sel + CNT_W'(1);
            end else begin
               dropped_in = 1'b1;
            end
            state_in = S_DONE;
         end

         // Hand the result to the output register once it is free.
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end

         // Greedy refill: empty all stacks, then list blocks from the top order down.
         S_RF_INIT: begin
            for (int k = 0; k < ORDER_COUNT; k++) begin
               fill_in[k] = '0;
            end
            counter_in = COUNT_W'(total_ff);
            rem_in     = total_ff;
            base_in    = '0;
            cur_in     = MAX_CUR;
            granted_in = '0;
            status_in  = bpa_pkg::ST_OK;
            dropped_in = 1'b0;
            state_in   = S_RF_ORD;
         end

         S_RF_ORD: begin
            blocks_in = rem_ff >> cur_ff;
            ptr_in    = base_ff;
            if ((rem_ff >> cur_ff) > DEPTH_PAGE) begin
               dropped_in = 1'b1;
            end
            state_in = S_RF_PUSH;
         end

         // The stack of this order started empty, so its fill count is the block index.
         S_RF_PUSH: begin
            if ((fill_sel < DEPTH_CNT) && (PAGE_W'(fill_sel) < blocks_ff)) begin
               ram_wr_en            = 1'b1;
               ram_wr_data          = ptr_ff;
               fill_in[fill_sel_ix] = fill_sel + CNT_W'(1);
               ptr_in               = ptr_ff + rf_step;
            end else begin
               rem_in  = rem_ff & rf_mask;
               base_in = base_ff + (rem_ff & ~rf_mask);
               if (cur_ff == CUR_ONE) begin
                  state_in = report_ff ? S_DONE : S_IDLE;
               end else begin
                  cur_in   = nxt_cur;
                  state_in = S_RF_ORD;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_RF_INIT;
         report_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         total_ff     <= bpa_pkg::TOTAL_RESET;
         for (int k = 0; k < ORDER_COUNT; k++) begin
            fill_ff[k] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         report_ff    <= report_in;
         rsp_valid_ff <= rsp_valid_in;
         fill_ff      <= fill_in;
         if (csr_ch.valid && csr_ch.ready) begin
            total_ff <= csr_ch.page_total;
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      ord_ff     <= ord_in;
      cur_ff     <= cur_in;
      page_ff    <= page_in;
      granted_ff <= granted_in;
      status_ff  <= status_in;
      dropped_ff <= dropped_in;
      counter_ff <= counter_in;
      rem_ff     <= rem_in;
      base_ff    <= base_in;
      ptr_ff     <= ptr_in;
      blocks_ff  <= blocks_in;
      if (rsp_load) begin
         rsp_status_ff  <= status_ff;
         rsp_granted_ff <= granted_ff;
         rsp_dropped_ff <= dropped_ff;
         rsp_count_ff   <= counter_ff;
      end
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.status          = rsp_status_ff;
   assign rsp_ch.granted_page    = rsp_granted_ff;
   assign rsp_ch.push_dropped    = rsp_dropped_ff;
   assign rsp_ch.free_page_count = rsp_count_ff;

   // The store port never reads and writes in the same cycle.
   a_ram_port_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(ram_wr_en && ram_rd_en))
      else $error("store read and write issued in the same cycle");

   // A pop is always followed by the cycle that captures its data.
   a_pop_then_read: assert property (@(posedge clock) disable iff (reset)
      ram_rd_en |=> (state_ff == S_READ))
      else $error("popped data not captured");

   // An accepted request always leaves the idle state.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff != S_IDLE))
      else $error("request accepted but sequencer stayed idle");

   // A loaded response is only overwritten after it was taken.
   a_rsp_not_lost: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (!rsp_valid_ff || rsp_ch.ready))
      else $error("pending response overwritten");

endmodule

`default_nettype wire

/* design/bpa_ram.sv */
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data.
module bpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port, data available the cycle after the address.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 100ps

module testbench;

   localparam int ACTION_W      = bpa_pkg::ACTION_W;
   localparam int ORDER_W       = bpa_pkg::ORDER_W;
   localparam int PAGE_W        = bpa_pkg::PAGE_W;
   localparam int STATUS_W      = bpa_pkg::STATUS_W;
   localparam int COUNT_W       = bpa_pkg::COUNT_W;
   localparam int MAX_ORDER_DEF = bpa_pkg::MAX_ORDER_DEF;

   localparam int ORDERS       = MAX_ORDER_DEF + 1;
   localparam int DEPTH        = bpa_pkg::STACK_DEPTH_DEF;
   localparam int ORDER_TOP    = (1 << ORDER_W) - 1;
   localparam int IDLE_LIMIT   = 4000;
   localparam int DRAIN_WAIT   = 40;
   localparam int RANDOM_ITEMS = 1100;
   localparam int CALM_TAIL    = 120;

   // Action code that the block leaves unused.
   localparam logic [ACTION_W-1:0] ACT_NONE = 2'd3;
   localparam logic [PAGE_W-1:0]   PAGE_MAX = '1;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [ORDER_W-1:0]  order;
      logic [PAGE_W-1:0]   page;
   } page_req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [PAGE_W-1:0]   granted;
      logic                dropped;
      logic [COUNT_W-1:0]  count;
   } page_rsp_type;

   typedef struct packed {
      page_req_type req;
      logic         typed;
      page_rsp_type want;
   } directed_row_type;

   typedef struct packed {
      logic [PAGE_W-1:0]  page;
      logic [ORDER_W-1:0] order;
   } held_block_type;

   localparam page_rsp_type NO_RSP = '0;
   localparam int DIRECTED_N = 23;

   // Directed sequence, starting from the reset fill of 1024 pages (one order-10 block at
   // page 0). Rows with a typed response are checked against it; the rest use the predictor.
   localparam directed_row_type DIRECTED [DIRECTED_N] = '{
      '{'{bpa_pkg::ACT_ALLOC, 4'd10, 18'd0}, 1'b1,
        '{bpa_pkg::ST_OK, 18'd0, 1'b0, 32'd0}},
      '{'{bpa_pkg::ACT_ALLOC, 4'd0, 18'd0}, 1'b1,
        '{bpa_pkg::ST_NO_BLOCK, 18'd0, 1'b0, 32'd0}},
      '{'{bpa_pkg::ACT_ALLOC, 4'd11, 18'd0}, 1'b1,
        '{bpa_pkg::ST_BAD_ORDER, 18'd0, 1'b0, 32'd0}},
      '{'{bpa_pkg::ACT_ALLOC, 4'd15, PAGE_MAX}, 1'b1,
        '{bpa_pkg::ST_BAD_ORDER, 18'd0, 1'b0, 32'd0}},
      '{'{bpa_pkg::ACT_FREE, 4'd15, PAGE_MAX}, 1'b1,
        '{bpa_pkg::ST_BAD_ORDER, 18'd0, 1'b0, 32'd0}},
      '{'{bpa_pkg::ACT_FREE, 4'd10, 18'd0}, 1'b1,
        '{bpa_pkg::ST_OK, 18'd0, 1'b0, 32'd1024}},
      '{'{bpa_pkg::ACT_ALLOC, 4'd0, 18'd0}, 1'b1,
        '{bpa_pkg::ST_OK, 18'd0, 1'b0, 32'd1023}},
      '{'{bpa_pkg::ACT_FREE, 4'd0, PAGE_MAX}, 1'b1,
        '{bpa_pkg::ST_OK, 18'd0, 1'b0, 32'd1024}},
      '{'{bpa_pkg::ACT_ALLOC, 4'd0, 18'd0}, 1'b1,
        '{bpa_pkg::ST_OK, PAGE_MAX, 1'b0, 32'd1023}},
      '{'{ACT_NONE, 4'd7, 18'h2AAAA}, 1'b1,
        '{bpa_pkg::ST_OK, 18'd0, 1'b0, 32'd1023}},
      '{'{bpa_pkg::ACT_ALLOC, 4'd3, 18'd0}, 1'b0, NO_RSP},
      '{'{bpa_pkg::ACT_ALLOC, 4'd5, 18'd0}, 1'b0, NO_RSP},
      '{'{bpa_pkg::ACT_FREE, 4'd10, PAGE_MAX}, 1'b0, NO_RSP},
      '{'{bpa_pkg::ACT_ALLOC, 4'd10, 18'd0}, 1'b0, NO_RSP},
      '{'{bpa_pkg::ACT_REINIT, 4'd0, 18'd0}, 1'b1,
        '{bpa_pkg::ST_OK, 18'd0, 1'b0, 32'd1024}},
      '{'{bpa_pkg::ACT_ALLOC, 4'd10, 18'd0}, 1'b1,
        '{bpa_pkg::ST_OK, 18'd0, 1'b0, 32'd0}},
      '{'{bpa_pkg::ACT_FREE, 4'd10, PAGE_MAX}, 1'b1,
        '{bpa_pkg::ST_OK, 18'd0, 1'b0, 32'd1024}},
      '{'{bpa_pkg::ACT_ALLOC, 4'd0, 18'd0}, 1'b1,
        '{bpa_pkg::ST_OK, PAGE_MAX, 1'b0, 32'd1023}},
      '{'{bpa_pkg::ACT_ALLOC, 4'd9, 18'd0}, 1'b0, NO_RSP},
      '{'{bpa_pkg::ACT_ALLOC, 4'd0, 18'd0}, 1'b0, NO_RSP},
      '{'{bpa_pkg::ACT_FREE, 4'd0, 18'd0}, 1'b0, NO_RSP},
      '{'{bpa_pkg::ACT_ALLOC, 4'd4, 18'h15555}, 1'b0, NO_RSP},
      '{'{bpa_pkg::ACT_REINIT, 4'd15, PAGE_MAX}, 1'b0, NO_RSP}
   };

   logic clock = 1'b0;
   logic reset;

   bpa_req_if req_bus ();
   bpa_rsp_if rsp_bus ();
   bpa_csr_if csr_bus ();

   buddy_page_allocator_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus),
      .csr_ch (csr_bus)
   );

   // Predictor state: one stack of free block pages per order, plus the counter and register.
   logic [PAGE_W-1:0]  free_stack [ORDERS][DEPTH];
   int unsigned        stack_level [ORDERS];
   logic [COUNT_W-1:0] free_count;
   logic [PAGE_W-1:0]  cfg_total;

   page_rsp_type   pending_rsp [$];
   held_block_type held [$];

   int  errors = 0;
   int  sent_count = 0;
   int  cfg_writes = 0;
   int  drops_seen = 0;
   int  no_block_seen = 0;
   int  bad_order_seen = 0;
   int  idle_cycles = 0;
   int  stall_left = 0;
   bit  calm = 1'b0;
   bit  tail = 1'b0;
   page_rsp_type want_rsp;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Push one block onto the stack of an order; a full stack drops it.
   function automatic bit push_block(int unsigned ord, logic [PAGE_W-1:0] page);
      if (stack_level[ord] >= DEPTH) return 1'b1;
      free_stack[ord][stack_level[ord]] = page;
      stack_level[ord]++;
      return 1'b0;
   endfunction

   // Greedy fill from the total-pages register, largest order first, starting at page 0.
   function automatic bit refill_stacks();
      int unsigned remaining;
      int unsigned base;
      int unsigned blocks;
      bit          dropped;
      dropped   = 1'b0;
      remaining = cfg_total;
      base      = 0;
      for (int o = 0; o < ORDERS; o++) stack_level[o] = 0;
      free_count = COUNT_W'(cfg_total);
      for (int o = MAX_ORDER_DEF; o > 0; o--) begin
         blocks = remaining >> o;
         if (blocks > DEPTH) dropped = 1'b1;
         for (int i = 0; i < blocks && i < DEPTH; i++) begin
            void'(push_block(o, PAGE_W'(base + (i << o))));
         end
         base      += blocks << o;
         remaining -= blocks << o;
      end
      return dropped;
   endfunction

   // Expected response of one request; updates the predictor state.
   function automatic page_rsp_type allocator_step(page_req_type r);
      page_rsp_type e;
      int unsigned  cur;
      e     = '0;
      case (r.action)
         bpa_pkg::ACT_ALLOC: begin
            if (r.order > MAX_ORDER_DEF) begin
               e.status = bpa_pkg::ST_BAD_ORDER;
            end else begin
               cur = r.order;
               while (cur <= MAX_ORDER_DEF && stack_level[cur] == 0) cur++;
               if (cur > MAX_ORDER_DEF) begin
                  e.status = bpa_pkg::ST_NO_BLOCK;
               end else begin
                  stack_level[cur]--;
                  e.granted = free_stack[cur][stack_level[cur]];
                  // Split down, listing each upper buddy on the next lower stack.
                  while (cur > r.order) begin
                     cur--;
                     if (push_block(cur, e.granted + PAGE_W'(1 << cur))) e.dropped = 1'b1;
                  end
                  free_count -= COUNT_W'(1) << r.order;
               end
            end
         end
         bpa_pkg::ACT_FREE: begin
            if (r.order > MAX_ORDER_DEF) begin
               e.status = bpa_pkg::ST_BAD_ORDER;
            end else begin
               e.dropped = push_block(r.order, r.page);
               free_count += COUNT_W'(1) << r.order;
            end
         end
         bpa_pkg::ACT_REINIT: begin
            e.dropped = refill_stacks();
         end
         default: begin
         end
      endcase
      e.count = free_count;
      return e;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
         errors++;
      end
   endtask

   // Drive one request transaction and record its expected response once it is accepted.
   task automatic send_req(input page_req_type r, input bit typed,
                           input page_rsp_type typed_rsp, output page_rsp_type predicted);
      int gap;
      gap  = 0;
      tail = (sent_count >= DIRECTED_N + RANDOM_ITEMS - CALM_TAIL);
      if (tail) calm = 1'b1;
      else if (sent_count % 64 == 0) calm = ($urandom_range(0, 3) == 0);
      if (!calm && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 6);
      @(negedge clock);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.action      <= r.action;
      req_bus.block_order <= r.order;
      req_bus.block_page  <= r.page;
      do @(posedge clock); while (!req_bus.ready);
      predicted = allocator_step(r);
      pending_rsp.push_back(typed ? typed_rsp : predicted);
      sent_count++;
   endtask

   // Write the total-pages register once every outstanding response has come back.
   task automatic write_total(input logic [PAGE_W-1:0] value);
      @(negedge clock);
      req_bus.valid <= 1'b0;
      wait (pending_rsp.size() == 0);
      @(negedge clock);
      csr_bus.valid      <= 1'b1;
      csr_bus.page_total <= value;
      do @(posedge clock); while (!csr_bus.ready);
      cfg_total = value;
      cfg_writes++;
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   // One random request: mostly allocations and frees of blocks handed out earlier.
   task automatic random_item();
      page_req_type   r;
      page_rsp_type   p;
      held_block_type b;
      int             roll;
      int             idx;
      roll    = $urandom_range(0, 99);
      r.page  = PAGE_W'($urandom);
      r.order = ORDER_W'($urandom_range(0, MAX_ORDER_DEF));
      if (roll < 45) begin
         r.action = bpa_pkg::ACT_ALLOC;
         if (roll < 3) r.order = ORDER_W'($urandom_range(MAX_ORDER_DEF + 1, ORDER_TOP));
      end else if (roll < 88) begin
         r.action = bpa_pkg::ACT_FREE;
         if (held.size() > 0 && roll < 80) begin
            idx = $urandom_range(0, held.size() - 1);
            b   = held[idx];
            held.delete(idx);
            r.page  = b.page;
            r.order = b.order;
         end else if (roll >= 86) begin
            r.order = ORDER_W'($urandom_range(MAX_ORDER_DEF + 1, ORDER_TOP));
         end
      end else if (roll < 93) begin
         r.action = bpa_pkg::ACT_REINIT;
      end else begin
         r.action = ACT_NONE;
      end
      send_req(r, 1'b0, NO_RSP, p);
      if (r.action == bpa_pkg::ACT_ALLOC && p.status == bpa_pkg::ST_OK) begin
         held.push_back('{p.granted, r.order});
      end else if (r.action == bpa_pkg::ACT_REINIT) begin
         held.delete();
      end
   endtask

   // Response side: random stall bursts, none while calm.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_bus.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
         stall_left = $urandom_range(1, 6) - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // Compare each response transaction with the oldest expected one.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t: response with none expected, expected nothing, got status %0d",
                     $time, rsp_bus.status);
            errors++;
         end else begin
            want_rsp = pending_rsp.pop_front();
            check_field("status", 32'(want_rsp.status), 32'(rsp_bus.status));
            check_field("granted_page", 32'(want_rsp.granted), 32'(rsp_bus.granted_page));
            check_field("push_dropped", 32'(want_rsp.dropped), 32'(rsp_bus.push_dropped));
            check_field("free_page_count", want_rsp.count, rsp_bus.free_page_count);
         end
         if (rsp_bus.push_dropped) drops_seen++;
         if (rsp_bus.status == bpa_pkg::ST_NO_BLOCK) no_block_seen++;
         if (rsp_bus.status == bpa_pkg::ST_BAD_ORDER) bad_order_seen++;
      end
   end

   // Watchdog: end the run after a long stretch with no transaction on any channel.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
             (csr_bus.valid && csr_bus.ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
            $display("status: fail");
            $finish;
         end
      end
   end

   initial begin
      page_req_type      r;
      page_rsp_type      p;
      logic [PAGE_W-1:0] total;
      int                phase;
      int                flood_order;

      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.action      = bpa_pkg::ACT_ALLOC;
      req_bus.block_order = '0;
      req_bus.block_page  = '0;
      rsp_bus.ready       = 1'b0;
      csr_bus.valid       = 1'b0;
      csr_bus.page_total  = '0;

      cfg_total = bpa_pkg::TOTAL_RESET;
      for (int o = 0; o < ORDERS; o++) begin
         for (int i = 0; i < DEPTH; i++) free_stack[o][i] = '0;
      end
      void'(refill_stacks());

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part.
      foreach (DIRECTED[i]) send_req(DIRECTED[i].req, DIRECTED[i].typed, DIRECTED[i].want, p);

      // Random phases, each under its own total-pages setting and starting with a refill.
      phase = 0;
      while (sent_count < DIRECTED_N + RANDOM_ITEMS) begin
         case (phase % 6)
            0:       total = '0;
            1:       total = PAGE_MAX;
            2:       total = PAGE_W'($urandom_range(0, 4095));
            3:       total = bpa_pkg::TOTAL_RESET;
            4:       total = PAGE_W'($urandom);
            default: total = PAGE_W'($urandom_range(1024, 16383));
         endcase
         write_total(total);
         held.delete();
         r = '{bpa_pkg::ACT_REINIT, ORDER_W'($urandom), PAGE_W'($urandom)};
         send_req(r, 1'b0, NO_RSP, p);

         // Overfill one stack with frees so that pushes are dropped, then drain it a little.
         if (phase % 4 == 1) begin
            flood_order = $urandom_range(0, MAX_ORDER_DEF);
            repeat ($urandom_range(DEPTH + 2, DEPTH + 8)) begin
               if (sent_count < DIRECTED_N + RANDOM_ITEMS) begin
                  r = '{bpa_pkg::ACT_FREE, ORDER_W'(flood_order), PAGE_W'($urandom)};
                  send_req(r, 1'b0, NO_RSP, p);
               end
            end
            repeat ($urandom_range(10, 30)) begin
               if (sent_count < DIRECTED_N + RANDOM_ITEMS) begin
                  r = '{bpa_pkg::ACT_ALLOC, ORDER_W'(flood_order), PAGE_W'($urandom)};
                  send_req(r, 1'b0, NO_RSP, p);
               end
            end
         end

         repeat ($urandom_range(60, 140)) begin
            if (sent_count < DIRECTED_N + RANDOM_ITEMS) random_item();
         end
         phase++;
      end

      @(negedge clock);
      req_bus.valid <= 1'b0;
      wait (pending_rsp.size() == 0);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (pending_rsp.size() != 0) begin
         $display("%0t: %0d responses never arrived", $time, pending_rsp.size());
         errors++;
      end

      $display("Ran %0d requests (%0d directed) over %0d phases with %0d register writes.",
               sent_count, DIRECTED_N, phase, cfg_writes);
      $display("Saw %0d dropped pushes, %0d empty-pool and %0d bad-order rejections; %0d errors.",
               drops_seen, no_block_seen, bad_order_seen, errors);
      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

/* sim.f */
design/bpa_pkg.sv
design/bpa_req_if.sv
design/bpa_rsp_if.sv
design/bpa_csr_if.sv
design/bpa_ram.sv
design/buddy_page_allocator_core.sv
tb/testbench.sv
